### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the branch predictor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### design/gbp_pkg.sv
// ----------------------------------------------------------------------------
// gbp_pkg
// Constants and codes shared by the global history branch predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbp_pkg;

   localparam int ADDR_W      = 64;
   localparam int HIST_W      = 64;
   localparam int MAX_ENTRIES = 1024;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int SIZE_W      = 11;
   localparam int HBITS_W     = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int STEP_W      = $clog2(ADDR_W + 1);

   localparam logic [SIZE_W-1:0]  TABLE_ENTRIES_RESET = SIZE_W'(256);
   localparam logic [SIZE_W-1:0]  SIZE_MAX            = SIZE_W'(MAX_ENTRIES);
   localparam logic [HBITS_W-1:0] HIST_MAX            = HBITS_W'(HIST_W);
   localparam logic [STEP_W-1:0]  DIV_STEPS           = STEP_W'(ADDR_W);

   localparam logic [1:0] CTR_MIN   = 2'd0;
   localparam logic [1:0] CTR_RESET = 2'd1;
   localparam logic [1:0] CTR_MAX   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_ENTRIES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_BITS  = CSR_IDX_W'(1);

endpackage

### design/gbp_divider.sv
// ----------------------------------------------------------------------------
// gbp_divider
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbp_divider
   import gbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [IDX_W-1:0]  remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] dvd_ff, dvd_in;
   logic [SIZE_W-1:0] dvs_ff, dvs_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [SIZE_W-1:0] trial;
   logic [SIZE_W-1:0] diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[ADDR_W-1]};
      diff    = trial - dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEPS;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[ADDR_W-2:0], 1'b0};
         rem_in  = (trial >= dvs_ff) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### design/global_history_branch_predictor_top.sv
// ----------------------------------------------------------------------------
// global_history_branch_predictor_top
// Gshare-style predictor update path: history shift, hashed index, counter
// check and update, one misprediction flag per resolved branch.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    branch_address, taken
//   rsp      out        rsp_valid/stall    mispredicted
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// Each branch passes from transfer to result through a hash state, the
// remainder steps and the registered done flag, a counter read, an update and
// the result load. After reset a clearing pass over all 1024 entries sets
// every counter to weakly not taken; req_stall stays high meanwhile. The
// result sits in an output register: a held rsp_stall lets the next transfer
// in but delays its result load, and req_stall stays high until that load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module global_history_branch_predictor_top
   import gbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ADDR_W-1:0]     req_branch_address,
   input  logic                  req_taken,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_mispredicted,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [SIZE_W-1:0]  entries_ff, entries_in;
   logic [HBITS_W-1:0] hbits_ff, hbits_in;
   logic [HIST_W-1:0]  hist_ff, hist_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               taken_ff, taken_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               miss_ff, miss_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_miss_ff, rsp_miss_in;

   logic [1:0]         ctr_mem [MAX_ENTRIES];
   logic [1:0]         rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [1:0]         mem_wdata;

   logic [SIZE_W-1:0]  act_size;
   logic [HBITS_W-1:0] act_hbits;
   logic [HBITS_W-1:0] shamt;
   logic [ADDR_W-1:0]  hashed;
   logic [1:0]         ctr_next;
   logic               req_xfer;
   logic               rsp_xfer;
   logic               div_start;
   logic               div_done;
   logic [IDX_W-1:0]   div_rem;

   always_comb begin
      priority if (entries_ff == '0) begin
         act_size = SIZE_W'(1);
      end else if (entries_ff > SIZE_MAX) begin
         act_size = SIZE_MAX;
      end else begin
         act_size = entries_ff;
      end
      act_hbits = (hbits_ff > HIST_MAX) ? HIST_MAX : hbits_ff;
      shamt     = HIST_MAX - act_hbits;
      hashed    = (act_hbits == '0) ? addr_ff
                                    : (addr_ff ^ (hist_ff << shamt[$clog2(HIST_W)-1:0]));
      if (taken_ff) begin
         ctr_next = (rdata_ff == CTR_MAX) ? CTR_MAX : rdata_ff + 2'd1;
      end else begin
         ctr_next = (rdata_ff == CTR_MIN) ? CTR_MIN : rdata_ff - 2'd1;
      end
   end

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign div_start = (state_ff == ST_HASH);

   gbp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hashed),
      .divisor   (act_size),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      entries_in   = entries_ff;
      hbits_in     = hbits_ff;
      hist_in      = hist_ff;
      addr_in      = addr_ff;
      taken_in     = taken_ff;
      idx_in       = idx_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_miss_in  = rsp_miss_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = ctr_next;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TABLE_ENTRIES: entries_in = csr_write_data[SIZE_W-1:0];
            CSR_HISTORY_BITS:  hbits_in   = csr_write_data[HBITS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = CTR_RESET;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               addr_in  = req_branch_address;
               taken_in = req_taken;
               hist_in  = (act_hbits == '0) ? '0 : {hist_ff[HIST_W-2:0], req_taken};
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               idx_in   = div_rem;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            mem_we   = 1'b1;
            miss_in  = taken_ff ^ rdata_ff[1];
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_valid_in = 1'b1;
               rsp_miss_in  = miss_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         entries_ff   <= TABLE_ENTRIES_RESET;
         hbits_ff     <= '0;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         entries_ff   <= entries_in;
         hbits_ff     <= hbits_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      taken_ff    <= taken_in;
      idx_ff      <= idx_in;
      miss_ff     <= miss_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   // counter table: one write port, registered read at the current index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ctr_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= ctr_mem[idx_ff];
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mispredicted = rsp_miss_ff;

   `ASSERT_IMPL(a_done_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE)
   `ASSERT_IMPL(a_index_in_range, clock, reset, state_ff == ST_READ, (({1'b0, idx_ff}) < act_size))
   `ASSERT_NEXT(a_accept_to_hash, clock, reset, req_xfer, state_ff == ST_HASH)
   `ASSERT_IMPL(a_no_history_when_off, clock, reset, ((state_ff == ST_HASH) && (act_hbits == '0)), hist_ff == '0)

endmodule
